/* rtl/fvc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fvc_pkg: shared types and constants of the voxel face culler
// Grid geometry, command and direction codes, item structs, neighbor lookup.
// ----------------------------------------------------------------------------
package fvc_pkg;

  // grid geometry
  localparam int GRID_SIDE = 16;
  localparam int COORD_W   = 4;
  localparam int AXIS_W    = (GRID_SIDE > 1) ? $clog2(GRID_SIDE) : 1;
  localparam int NB_W      = ((AXIS_W > COORD_W) ? AXIS_W : COORD_W) + 1;
  localparam int ADDR_W    = 3 * AXIS_W;
  localparam int MEM_DEPTH = 1 << ADDR_W;

  // result widths
  localparam int DIR_W    = 3;
  localparam int SHADE_W  = 8;
  localparam int VTX_W    = 17;
  localparam int NUM_DIRS = 6;
  localparam int RD_W     = 3;

  // command queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QP_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  // shade levels: light factor times 255, rounded to nearest
  localparam logic [SHADE_W-1:0] SHADE_Z      = 8'd219;
  localparam logic [SHADE_W-1:0] SHADE_X      = 8'd204;
  localparam logic [SHADE_W-1:0] SHADE_BOTTOM = 8'd153;
  localparam logic [SHADE_W-1:0] SHADE_TOP    = 8'd255;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_MESH  = 1'b1
  } cmd_e;

  typedef enum logic [DIR_W-1:0] {
    DIR_NORTH  = 3'd0,
    DIR_SOUTH  = 3'd1,
    DIR_WEST   = 3'd2,
    DIR_EAST   = 3'd3,
    DIR_BOTTOM = 3'd4,
    DIR_TOP    = 3'd5
  } dir_e;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_READ,
    BK_EMIT
  } back_state_e;

  // one input transaction
  typedef struct packed {
    logic                 cmd;
    logic [COORD_W-1:0]   cell_x;
    logic [COORD_W-1:0]   cell_y;
    logic [COORD_W-1:0]   cell_z;
    logic                 solid;
  } item_t;

  // one visible face
  typedef struct packed {
    logic [COORD_W-1:0]   face_x;
    logic [COORD_W-1:0]   face_y;
    logic [COORD_W-1:0]   face_z;
    logic [DIR_W-1:0]     face_dir;
    logic [SHADE_W-1:0]   shade;
    logic [VTX_W-1:0]     first_vertex;
    logic                 last_face;
  } face_t;

  // classified operation held in the queue
  typedef struct packed {
    logic                 is_mesh;
    logic [AXIS_W-1:0]    x;
    logic [AXIS_W-1:0]    y;
    logic [AXIS_W-1:0]    z;
    logic                 solid;
  } op_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic              on_grid;
    logic [ADDR_W-1:0] addr;
  } nb_t;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [AXIS_W-1:0] x,
                                                  input logic [AXIS_W-1:0] y,
                                                  input logic [AXIS_W-1:0] z);
    return {z, y, x};
  endfunction

  function automatic logic [SHADE_W-1:0] shade_of(input logic [DIR_W-1:0] dir);
    logic [SHADE_W-1:0] s;
    case (dir)
      DIR_NORTH, DIR_SOUTH: s = SHADE_Z;
      DIR_WEST, DIR_EAST:   s = SHADE_X;
      DIR_BOTTOM:           s = SHADE_BOTTOM;
      DIR_TOP:              s = SHADE_TOP;
      default:              s = '0;
    endcase
    return s;
  endfunction

  // neighbor address in one direction, with an in-grid flag
  function automatic nb_t neighbor(input logic [AXIS_W-1:0] x,
                                   input logic [AXIS_W-1:0] y,
                                   input logic [AXIS_W-1:0] z,
                                   input logic [DIR_W-1:0]  dir);
    logic [NB_W-1:0] ex;
    logic [NB_W-1:0] ey;
    logic [NB_W-1:0] ez;
    logic            ok;
    nb_t             r;
    ex = NB_W'(x);
    ey = NB_W'(y);
    ez = NB_W'(z);
    ok = 1'b1;
    case (dir)
      DIR_NORTH: begin
        if (ez == '0) ok = 1'b0;
        else ez = ez - 1'b1;
      end
      DIR_SOUTH: ez = ez + 1'b1;
      DIR_WEST: begin
        if (ex == '0) ok = 1'b0;
        else ex = ex - 1'b1;
      end
      DIR_EAST: ex = ex + 1'b1;
      DIR_BOTTOM: begin
        if (ey == '0) ok = 1'b0;
        else ey = ey - 1'b1;
      end
      DIR_TOP: ey = ey + 1'b1;
      default: ok = 1'b0;
    endcase
    r.on_grid = ok && (ex < NB_W'(GRID_SIDE)) && (ey < NB_W'(GRID_SIDE)) &&
                (ez < NB_W'(GRID_SIDE));
    r.addr    = {ez[AXIS_W-1:0], ey[AXIS_W-1:0], ex[AXIS_W-1:0]};
    return r;
  endfunction

endpackage

/* rtl/fvc_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fvc_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module fvc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* rtl/fvc_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fvc_queue: short operation queue between front and back
// Holds classified operations so that either side can stall on its own.
// ----------------------------------------------------------------------------
module fvc_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  fvc_pkg::op_t   push_op,
  input  logic           pop,
  output fvc_pkg::op_t   head,
  output fvc_pkg::q_stat_t stat
);
  import fvc_pkg::*;

  op_t             entries [QUEUE_DEPTH];
  logic [QP_W-1:0] wr_ptr;
  logic [QP_W-1:0] rd_ptr;
  logic [QP_W:0]   count;

  // status and head entry
  always_comb begin
    stat.full  = (count == (QP_W + 1)'(QUEUE_DEPTH));
    stat.empty = (count == '0);
    head       = entries[rd_ptr];
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_op;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == QP_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == QP_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // checks
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push && !pop |-> !stat.full)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !stat.empty)
    else $error("queue pop while empty");

endmodule

/* rtl/fvc_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fvc_front: command intake and classification
// Takes commands, drops writes and meshes outside the grid, queues the rest.
// ----------------------------------------------------------------------------
module fvc_front (
  input  logic             start,
  input  fvc_pkg::item_t   item,
  input  fvc_pkg::q_stat_t q_stat,
  input  logic             clearing,
  output logic             busy,
  output logic             push,
  output fvc_pkg::op_t     push_op
);
  import fvc_pkg::*;

  logic accept;
  logic in_grid;

  // handshake
  always_comb begin
    busy   = q_stat.full || clearing;
    accept = start && !busy;
  end

  // classify: only in-grid cells cause any work
  always_comb begin
    in_grid = (NB_W'(item.cell_x) < NB_W'(GRID_SIDE)) &&
              (NB_W'(item.cell_y) < NB_W'(GRID_SIDE)) &&
              (NB_W'(item.cell_z) < NB_W'(GRID_SIDE));
    push            = accept && in_grid;
    push_op.is_mesh = (item.cmd == CMD_MESH);
    push_op.x       = AXIS_W'(item.cell_x);
    push_op.y       = AXIS_W'(item.cell_y);
    push_op.z       = AXIS_W'(item.cell_z);
    push_op.solid   = item.solid;
  end

endmodule

/* rtl/fvc_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fvc_back: occupancy store and face emitter
// Clears the grid after reset, applies writes, reads a cell and its six
// neighbors; a solid cell gets at most one face per cycle, per air/edge side.
// ----------------------------------------------------------------------------
module fvc_back (
  input  logic             clk,
  input  logic             rst,
  input  fvc_pkg::op_t     head,
  input  fvc_pkg::q_stat_t q_stat,
  output logic             pop,
  output logic             clearing,
  output fvc_pkg::face_t   face,
  output logic             face_valid
);
  import fvc_pkg::*;

  back_state_e           state;
  back_state_e           state_next;
  logic [ADDR_W-1:0]     clr_addr;
  op_t                   op;
  logic [RD_W-1:0]       rd_idx;
  logic                  rd_inside;
  logic                  center_solid;
  logic [NUM_DIRS-1:0]   nb_solid;
  logic [DIR_W-1:0]      dir_idx;
  logic [VTX_W-1:0]      vertex_counter;

  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr;
  logic                  ram_wdata;
  logic [ADDR_W-1:0]     ram_raddr;
  logic                  ram_rdata;

  nb_t                   rd_nb;
  logic [NUM_DIRS-1:0]   vis_mask;
  logic                  vis;
  logic                  last;
  logic                  emit_done;

  fvc_ram #(
    .WIDTH (1),
    .DEPTH (MEM_DEPTH)
  ) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // read address for the current read step: center first, then directions
  always_comb begin
    if (rd_idx == '0) begin
      rd_nb.on_grid = 1'b1;
      rd_nb.addr    = cell_addr(op.x, op.y, op.z);
    end else begin
      rd_nb = neighbor(op.x, op.y, op.z, DIR_W'(rd_idx - 1'b1));
    end
  end

  // visibility of the current direction and last-face lookahead
  always_comb begin
    vis_mask = {NUM_DIRS{center_solid}} & ~nb_solid;
    vis      = vis_mask[dir_idx];
    last     = 1'b1;
    for (int d = 0; d < NUM_DIRS; d++) begin
      if (DIR_W'(d) > dir_idx && vis_mask[d]) last = 1'b0;
    end
    emit_done = (dir_idx == DIR_W'(NUM_DIRS - 1)) || (vis && last);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      BK_CLEAR: if (clr_addr == ADDR_W'(MEM_DEPTH - 1)) state_next = BK_IDLE;
      BK_IDLE:  if (!q_stat.empty && head.is_mesh) state_next = BK_READ;
      BK_READ:  if (rd_idx == RD_W'(NUM_DIRS + 1)) state_next = BK_EMIT;
      BK_EMIT:  if (emit_done) state_next = BK_IDLE;
      default:  state_next = BK_CLEAR;
    endcase
  end

  // outputs to memory and queue
  always_comb begin
    clearing  = (state == BK_CLEAR);
    pop       = (state == BK_IDLE) && !q_stat.empty;
    ram_we    = 1'b0;
    ram_waddr = cell_addr(head.x, head.y, head.z);
    ram_wdata = head.solid;
    ram_raddr = rd_nb.addr;
    case (state)
      BK_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = 1'b0;
      end
      BK_IDLE: ram_we = !q_stat.empty && !head.is_mesh;
      default: ram_we = 1'b0;
    endcase
  end

  // state and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= BK_CLEAR;
      clr_addr       <= '0;
      vertex_counter <= '0;
      face_valid     <= 1'b0;
      rd_idx         <= '0;
      dir_idx        <= '0;
    end else begin
      state      <= state_next;
      face_valid <= 1'b0;
      if (state == BK_CLEAR) clr_addr <= clr_addr + 1'b1;
      if (state == BK_IDLE) begin
        rd_idx  <= '0;
        dir_idx <= '0;
      end
      if (state == BK_READ) rd_idx <= rd_idx + 1'b1;
      if (state == BK_EMIT) begin
        dir_idx <= dir_idx + 1'b1;
        if (vis) begin
          face_valid     <= 1'b1;
          vertex_counter <= vertex_counter + VTX_W'(4);
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == BK_IDLE && pop) op <= head;
    if (state == BK_READ) begin
      rd_inside <= rd_nb.on_grid;
      if (rd_idx == RD_W'(1)) center_solid <= ram_rdata && rd_inside;
      for (int d = 0; d < NUM_DIRS; d++) begin
        if (rd_idx == RD_W'(d + 2)) nb_solid[d] <= ram_rdata && rd_inside;
      end
    end
    if (state == BK_EMIT && vis) begin
      face.face_x       <= COORD_W'(op.x);
      face.face_y       <= COORD_W'(op.y);
      face.face_z       <= COORD_W'(op.z);
      face.face_dir     <= dir_idx;
      face.shade        <= shade_of(dir_idx);
      face.first_vertex <= vertex_counter;
      face.last_face    <= last;
    end
  end

  // checks
  a_face_from_emit: assert property (@(posedge clk) disable iff (rst)
    face_valid |-> $past(state) == BK_EMIT)
    else $error("face strobe outside emit phase");
  a_vertex_step: assert property (@(posedge clk) disable iff (rst)
    face_valid && $past(face_valid) |->
      face.first_vertex == VTX_W'($past(face.first_vertex) + VTX_W'(4)))
    else $error("vertex number did not advance by four");
  a_no_write_in_mesh: assert property (@(posedge clk) disable iff (rst)
    (state == BK_READ || state == BK_EMIT) |-> !ram_we)
    else $error("grid write during mesh");
  a_last_ends_burst: assert property (@(posedge clk) disable iff (rst)
    face_valid && face.last_face |=> !face_valid)
    else $error("face after last face");

endmodule

/* rtl/voxel_face_culler.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_face_culler: culled-face mesher over a cubic occupancy grid
// Writes set cells solid or air; a mesh command emits the visible faces of
// one solid cell with shade and first vertex number.
//
//   channel   ports                    handshake
//   command   start, busy, item        taken when start && !busy
//   faces     face_valid, face         one-cycle strobe, no back-pressure
//
// A write is applied to the grid as it leaves the queue. A mesh command leaves
// the queue, reads the center and six neighbors through the single grid read
// port, whose output is registered, then steps through the directions with at
// most one face per cycle, ending at the last visible face or last direction;
// each strobe is registered, in the cycle after its emit step. After reset the
// grid is cleared one cell a cycle, all 4096 cells, with busy high. A
// two-entry queue lets commands be taken while the back end works; busy rises
// only when full or while the grid is cleared. The face receiver cannot stall.
// ----------------------------------------------------------------------------
module voxel_face_culler (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  fvc_pkg::item_t item,
  output logic           busy,
  output fvc_pkg::face_t face,
  output logic           face_valid
);
  import fvc_pkg::*;

  q_stat_t q_stat;
  logic    push;
  op_t     push_op;
  logic    pop;
  op_t     head;
  logic    clearing;

  // command intake
  fvc_front u_front (
    .start    (start),
    .item     (item),
    .q_stat   (q_stat),
    .clearing (clearing),
    .busy     (busy),
    .push     (push),
    .push_op  (push_op)
  );

  // operation queue
  fvc_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .head    (head),
    .stat    (q_stat)
  );

  // grid and face emitter
  fvc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .q_stat     (q_stat),
    .pop        (pop),
    .clearing   (clearing),
    .face       (face),
    .face_valid (face_valid)
  );

endmodule
